// File: hw/rtl/gmfrd_pkg.sv
// Package: shared constants, item types and request codes for the run detector.
package gmfrd_pkg;

   localparam int ONE_SIDED_TAPS = 31;
   localparam int MAX_BLOCK      = 65536;
   localparam int SAMPLE_BITS    = 16;

   localparam int TAP_COUNT   = ONE_SIDED_TAPS + 1;
   localparam int LINE_LEN    = 2 * ONE_SIDED_TAPS + 1;
   localparam int TAP_BITS    = 16;
   localparam int PROD_BITS   = SAMPLE_BITS + TAP_BITS + 1;
   localparam int ACC_BITS    = PROD_BITS + $clog2(LINE_LEN);
   localparam int COUNT_BITS  = $clog2(MAX_BLOCK) + 1;
   localparam int STEP_BITS   = $clog2(LINE_LEN);
   localparam int DIST_BITS   = $clog2(TAP_COUNT);
   localparam int FLUSH_BITS  = $clog2(ONE_SIDED_TAPS + 1);
   localparam int THR_BITS    = 39;
   localparam int SCALE_BITS  = 16;
   localparam int MAXDET_BITS = 16;
   localparam int SNR_BITS    = 32;
   localparam int ADDR_BITS   = 5;
   localparam int DATA_BITS   = 64;

   localparam logic [1:0] REQ_TAP    = 2'd0;
   localparam logic [1:0] REQ_SAMPLE = 2'd1;
   localparam logic [1:0] REQ_FLUSH  = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_SCALE     = 2'd1;
   localparam logic [1:0] REG_MAXDET    = 2'd2;

   typedef struct packed {
      logic [1:0]                    req_type;
      logic [4:0]                    tap_index;
      logic [TAP_BITS-1:0]           tap_value;
      logic signed [SAMPLE_BITS-1:0] sample;
   } req_item_type;

   typedef struct packed {
      logic signed [SNR_BITS-1:0] snr_value;
      logic [15:0]                sample_index;
      logic                       run_found;
      logic [15:0]                run_start;
      logic [16:0]                run_end;
      logic                       last;
   } rsp_item_type;

endpackage

// File: hw/rtl/gaussian_matched_filter_run_detector_unit.sv
// Top level: symmetric Gaussian FIR over a chain of delay cells, SNR and run detection.
//
// Items arrive on req_ (valid/ready): tap loads, data samples and end-of-block
// flushes. Each data sample past the first 31 of a block yields one result on
// rsp_ for the sample 31 positions earlier; a flush yields the remaining
// (up to 31) results, the final one marked last, then clears the block.
// Results carry a scaled, saturated SNR and, when a run above the threshold
// closes, its start and end-exclusive index.
// Per output the 63-cell delay line rotates once past a single multiply-
// accumulate unit, then the SNR scaler runs. req_ready is low from the sample
// or flush that starts a result until that result is loaded, so no new item
// is taken meanwhile. A flush runs the MAC pass and the scaler once per
// pending output.
// The output register holds a result until rsp_ready; the block moves on to
// the next item meanwhile and only waits when a new result is ready and the
// register is still full.
// Reset (synchronous, active high) clears taps, the delay line, block and run
// state; threshold 0, snr_scale 65535, run limit 65535.
// Registers on the APB port at byte 0, 8, 16 (64-bit data).
module gaussian_matched_filter_run_detector_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  gmfrd_pkg::req_item_type              req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gmfrd_pkg::rsp_item_type              rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [gmfrd_pkg::ADDR_BITS-1:0]      paddr,
   input  logic [gmfrd_pkg::DATA_BITS-1:0]      pwdata,
   output logic [gmfrd_pkg::DATA_BITS-1:0]      prdata,
   output logic                                 pready
);

   typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_SCALE, ST_EMIT} state_type;

   localparam int SB = gmfrd_pkg::SAMPLE_BITS;
   localparam int CB = gmfrd_pkg::COUNT_BITS;
   localparam int N  = gmfrd_pkg::LINE_LEN;
   localparam int K  = gmfrd_pkg::ONE_SIDED_TAPS;

   state_type state_ff;
   logic [gmfrd_pkg::THR_BITS-1:0]    thr_ff;
   logic [gmfrd_pkg::SCALE_BITS-1:0]  scale_ff;
   logic [gmfrd_pkg::MAXDET_BITS-1:0] maxdet_ff;
   logic [gmfrd_pkg::TAP_BITS-1:0]    tap_ff [gmfrd_pkg::TAP_COUNT];
   logic [CB-1:0]                     count_ff;
   logic [CB-1:0]                     idx_ff;
   logic [gmfrd_pkg::STEP_BITS-1:0]   step_ff;
   logic [gmfrd_pkg::FLUSH_BITS-1:0]  left_ff;
   logic                              flushing_ff;
   logic signed [gmfrd_pkg::ACC_BITS-1:0] acc_ff;
   logic                              in_run_ff, stopped_ff;
   logic [15:0]                       run_start_ff, det_count_ff;
   logic                              rsp_valid_ff;
   gmfrd_pkg::rsp_item_type           rsp_ff;

   logic signed [SB-1:0] cell_q [N];
   logic signed [SB-1:0] head_in;
   logic                 line_move, line_clear, snr_done;
   logic signed [gmfrd_pkg::SNR_BITS-1:0] snr;
   logic [gmfrd_pkg::DIST_BITS-1:0]       tap_dist;
   logic signed [gmfrd_pkg::PROD_BITS-1:0] prod;
   logic                 accept, cfg_wr, load_out;
   logic                 is_last, found, above, in_run_in, stopped_in;
   logic [15:0]          run_start_in, det_count_in, rs;
   logic [16:0]          re;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign cfg_wr    = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign load_out  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign is_last   = flushing_ff && (left_ff == gmfrd_pkg::FLUSH_BITS'(1));

   always_comb begin
      case (paddr[4:3])
         gmfrd_pkg::REG_THRESHOLD: prdata = gmfrd_pkg::DATA_BITS'(thr_ff);
         gmfrd_pkg::REG_SCALE:     prdata = gmfrd_pkg::DATA_BITS'(scale_ff);
         gmfrd_pkg::REG_MAXDET:    prdata = gmfrd_pkg::DATA_BITS'(maxdet_ff);
         default:                  prdata = '0;
      endcase
   end

   // cell chain: shift in on a new sample or flush step, rotate during the MAC pass
   always_comb begin
      line_move = 1'b0;
      head_in   = cell_q[N-1];
      if (state_ff == ST_MAC) begin
         line_move = 1'b1;
      end else if (accept && req_data.req_type == gmfrd_pkg::REQ_SAMPLE
                   && count_ff < CB'(gmfrd_pkg::MAX_BLOCK)) begin
         line_move = 1'b1;
         head_in   = req_data.sample;
      end else if (accept && req_data.req_type == gmfrd_pkg::REQ_FLUSH
                   && count_ff != '0) begin
         line_move = 1'b1;
         head_in   = '0;
      end else if (load_out && flushing_ff && !is_last) begin
         line_move = 1'b1;
         head_in   = '0;
      end
   end

   assign line_clear = (accept && req_data.req_type == gmfrd_pkg::REQ_FLUSH
                        && count_ff == '0) || (load_out && is_last);

   for (genvar i = 0; i < N; i++) begin : g_cell
      gmfrd_cell u_cell (
         .clock (clock),
         .reset (reset),
         .clear (line_clear),
         .move  (line_move),
         .din   ((i == 0) ? head_in : cell_q[(i == 0) ? 0 : i-1]),
         .dout  (cell_q[i])
      );
   end

   always_comb begin
      if (step_ff < gmfrd_pkg::STEP_BITS'(K)) begin
         tap_dist = gmfrd_pkg::DIST_BITS'(gmfrd_pkg::STEP_BITS'(K) - step_ff);
      end else begin
         tap_dist = gmfrd_pkg::DIST_BITS'(step_ff - gmfrd_pkg::STEP_BITS'(K));
      end
      prod = cell_q[N-1] * $signed({1'b0, tap_ff[tap_dist]});
   end

   gmfrd_snr u_snr (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_MAC && step_ff == gmfrd_pkg::STEP_BITS'(N-1)),
      .acc   (acc_ff),
      .scale (scale_ff),
      .done  (snr_done),
      .snr   (snr)
   );

   // run detection for the output being emitted
   always_comb begin
      stopped_in   = stopped_ff;
      in_run_in    = in_run_ff;
      run_start_in = run_start_ff;
      det_count_in = det_count_ff;
      found        = 1'b0;
      rs           = '0;
      re           = '0;
      above        = !acc_ff[gmfrd_pkg::ACC_BITS-1] && acc_ff != '0
                     && $unsigned(acc_ff) > thr_ff;
      if (!stopped_in && det_count_in >= maxdet_ff) begin
         stopped_in = 1'b1;
         in_run_in  = 1'b0;
      end
      if (!stopped_in) begin
         if (above) begin
            if (!in_run_in) begin
               in_run_in    = 1'b1;
               run_start_in = idx_ff[15:0];
            end
            if (is_last) begin
               found = 1'b1;
               rs    = run_start_in;
               re    = 17'(idx_ff + CB'(1));
            end
         end else if (in_run_in) begin
            found = 1'b1;
            rs    = run_start_in;
            re    = 17'(idx_ff);
         end
         if (found) begin
            in_run_in    = 1'b0;
            det_count_in = det_count_in + 16'd1;
            if (det_count_in >= maxdet_ff) begin
               stopped_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= '0;
         scale_ff  <= '1;
         maxdet_ff <= '1;
      end else if (cfg_wr) begin
         case (paddr[4:3])
            gmfrd_pkg::REG_THRESHOLD: thr_ff    <= pwdata[gmfrd_pkg::THR_BITS-1:0];
            gmfrd_pkg::REG_SCALE:     scale_ff  <= pwdata[gmfrd_pkg::SCALE_BITS-1:0];
            gmfrd_pkg::REG_MAXDET:    maxdet_ff <= pwdata[gmfrd_pkg::MAXDET_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gmfrd_pkg::TAP_COUNT; i++) begin
            tap_ff[i] <= '0;
         end
      end else if (accept && req_data.req_type == gmfrd_pkg::REQ_TAP) begin
         tap_ff[req_data.tap_index] <= req_data.tap_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         step_ff      <= '0;
         left_ff      <= '0;
         flushing_ff  <= 1'b0;
         in_run_ff    <= 1'b0;
         stopped_ff   <= 1'b0;
         run_start_ff <= '0;
         det_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               step_ff <= '0;
               if (accept && req_data.req_type == gmfrd_pkg::REQ_SAMPLE
                   && count_ff < CB'(gmfrd_pkg::MAX_BLOCK)) begin
                  count_ff <= count_ff + CB'(1);
                  if (count_ff >= CB'(K)) begin
                     idx_ff   <= count_ff - CB'(K);
                     state_ff <= ST_MAC;
                  end
               end else if (accept && req_data.req_type == gmfrd_pkg::REQ_FLUSH) begin
                  if (count_ff == '0) begin
                     in_run_ff    <= 1'b0;
                     stopped_ff   <= 1'b0;
                     run_start_ff <= '0;
                     det_count_ff <= '0;
                  end else if (count_ff < CB'(K)) begin
                     left_ff     <= gmfrd_pkg::FLUSH_BITS'(count_ff);
                     idx_ff      <= '0;
                     flushing_ff <= 1'b1;
                     state_ff    <= ST_MAC;
                  end else begin
                     left_ff     <= gmfrd_pkg::FLUSH_BITS'(K);
                     idx_ff      <= count_ff - CB'(K);
                     flushing_ff <= 1'b1;
                     state_ff    <= ST_MAC;
                  end
               end
            end
            ST_MAC: begin
               if (step_ff == '0) begin
                  acc_ff <= gmfrd_pkg::ACC_BITS'(prod);
               end else begin
                  acc_ff <= acc_ff + gmfrd_pkg::ACC_BITS'(prod);
               end
               if (step_ff == gmfrd_pkg::STEP_BITS'(N-1)) begin
                  state_ff <= ST_SCALE;
               end else begin
                  step_ff <= step_ff + gmfrd_pkg::STEP_BITS'(1);
               end
            end
            ST_SCALE: begin
               if (snr_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (load_out) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_ff.snr_value      <= snr;
                  rsp_ff.sample_index   <= idx_ff[15:0];
                  rsp_ff.run_found      <= found;
                  rsp_ff.run_start      <= rs;
                  rsp_ff.run_end        <= re;
                  rsp_ff.last           <= is_last;
                  step_ff               <= '0;
                  if (is_last) begin
                     flushing_ff  <= 1'b0;
                     count_ff     <= '0;
                     in_run_ff    <= 1'b0;
                     stopped_ff   <= 1'b0;
                     run_start_ff <= '0;
                     det_count_ff <= '0;
                     state_ff     <= ST_IDLE;
                  end else begin
                     in_run_ff    <= in_run_in;
                     stopped_ff   <= stopped_in;
                     run_start_ff <= run_start_in;
                     det_count_ff <= det_count_in;
                     if (flushing_ff) begin
                        left_ff  <= left_ff - gmfrd_pkg::FLUSH_BITS'(1);
                        idx_ff   <= idx_ff + CB'(1);
                        state_ff <= ST_MAC;
                     end else begin
                        state_ff <= ST_IDLE;
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(gmfrd_pkg::MAX_BLOCK))
      else $error("block count beyond limit");

   a_flush_left: assert property (@(posedge clock) disable iff (reset)
      flushing_ff && state_ff != ST_IDLE |-> left_ff != '0)
      else $error("flush running with nothing left");

   a_scale_done: assert property (@(posedge clock) disable iff (reset)
      snr_done |-> state_ff == ST_SCALE)
      else $error("scaler finished outside its wait");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("held result overwritten");

endmodule

// File: hw/rtl/gmfrd_cell.sv
// One delay-line cell: holds a sample and takes its neighbour's on each move.
module gmfrd_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   clear,
   input  logic                                   move,
   input  logic signed [gmfrd_pkg::SAMPLE_BITS-1:0] din,
   output logic signed [gmfrd_pkg::SAMPLE_BITS-1:0] dout
);

   logic signed [gmfrd_pkg::SAMPLE_BITS-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         value_ff <= '0;
      end else if (move) begin
         value_ff <= din;
      end
   end

   assign dout = value_ff;

endmodule

// File: hw/rtl/gmfrd_snr.sv
// SNR scaling: accumulator times scale, floor shift by 16, saturate, two stages.
module gmfrd_snr (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic signed [gmfrd_pkg::ACC_BITS-1:0]    acc,
   input  logic [gmfrd_pkg::SCALE_BITS-1:0]         scale,
   output logic                                     done,
   output logic signed [gmfrd_pkg::SNR_BITS-1:0]    snr
);

   localparam int LO_BITS = 20;
   localparam int HI_BITS = gmfrd_pkg::ACC_BITS - LO_BITS;
   localparam int LP_BITS = LO_BITS + gmfrd_pkg::SCALE_BITS;
   localparam int HP_BITS = HI_BITS + gmfrd_pkg::SCALE_BITS + 1;
   localparam int P_BITS  = gmfrd_pkg::ACC_BITS + gmfrd_pkg::SCALE_BITS + 1;
   localparam int Q_BITS  = P_BITS - 16;

   logic                      s1_ff, s2_ff;
   logic [LP_BITS-1:0]        lo_ff, lo_in;
   logic signed [HP_BITS-1:0] hi_ff, hi_in;
   logic signed [gmfrd_pkg::SNR_BITS-1:0] snr_ff, snr_in;
   logic signed [P_BITS-1:0]  prod;
   logic signed [Q_BITS-1:0]  quot;

   always_comb begin
      lo_in = LP_BITS'(acc[LO_BITS-1:0]) * LP_BITS'(scale);
      hi_in = $signed(acc[gmfrd_pkg::ACC_BITS-1:LO_BITS])
              * $signed({1'b0, scale});
      prod  = ($signed(P_BITS'(hi_ff)) <<< LO_BITS) + $signed(P_BITS'(lo_ff));
      quot  = Q_BITS'(prod >>> 16);
      if (quot > $signed(Q_BITS'(32'sh7FFF_FFFF))) begin
         snr_in = 32'sh7FFF_FFFF;
      end else if (quot < -$signed(Q_BITS'(33'sh0_8000_0000))) begin
         snr_in = 32'sh8000_0000;
      end else begin
         snr_in = quot[gmfrd_pkg::SNR_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= start;
         s2_ff <= s1_ff;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      snr_ff <= snr_in;
   end

   assign done = s2_ff;
   assign snr  = snr_ff;

endmodule
